@@ hdl/base64_stream_codec_unit_assert.svh @@
// ----------------------------------------------------------------------------
// base64 stream codec assertion macros
// clocked property helpers shared by the codec modules
// ----------------------------------------------------------------------------
`ifndef BASE64_STREAM_CODEC_UNIT_ASSERT_SVH
`define BASE64_STREAM_CODEC_UNIT_ASSERT_SVH

// same-cycle implication, held off while in reset
`define B64SC_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, held off while in reset
`define B64SC_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ hdl/b64sc_pkg.sv @@
// ----------------------------------------------------------------------------
// b64sc_pkg
// types, constants and alphabet functions of the base64 stream codec
// ----------------------------------------------------------------------------
package b64sc_pkg;

	localparam int JOB_SLOTS   = 4;
	localparam int QUEUE_DEPTH = 2;
	localparam int ADDR_W      = 3;

	// register index as seen on paddr[2]
	localparam logic REG_DIRECTION = 1'b0;

	localparam logic DIR_ENCODE = 1'b0;
	localparam logic DIR_DECODE = 1'b1;

	localparam logic [7:0] PAD_CHAR = 8'h3D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_LF    = 8'h0A;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       in_last;
	} in_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       out_valid;
		logic       out_last;
		logic       bad_input;
	} out_t;

	// one accepted word's worth of results, slot 0 goes out first
	typedef struct packed {
		out_t [JOB_SLOTS-1:0] res;
		logic [2:0]           count;
	} job_t;

	typedef struct packed {
		logic direction;
		logic clear;
	} cfg_ctl_t;

	typedef struct packed {
		logic [5:0] value;
		logic       is_pad;
		logic       is_bad;
	} sextet_t;

	function automatic logic [7:0] enc_char(input logic [5:0] v);
		logic [7:0] w;
		w = {2'b00, v};
		if (v < 6'd26)      return 8'(w + 8'h41);
		else if (v < 6'd52) return 8'(w + 8'd71);
		else if (v < 6'd62) return 8'(w - 8'd4);
		else if (v == 6'd62) return 8'h2B;
		else                return 8'h2F;
	endfunction

	function automatic sextet_t dec_char(input logic [7:0] c);
		sextet_t s;
		s = '0;
		priority if (c >= 8'h41 && c <= 8'h5A) s.value = 6'(c - 8'h41);
		else if (c >= 8'h61 && c <= 8'h7A)     s.value = 6'(c - 8'd71);
		else if (c >= 8'h30 && c <= 8'h39)     s.value = 6'(c + 8'd4);
		else if (c == 8'h2B)                   s.value = 6'd62;
		else if (c == 8'h2F)                   s.value = 6'd63;
		else if (c == PAD_CHAR)                s.is_pad = 1'b1;
		else                                   s.is_bad = 1'b1;
		return s;
	endfunction

endpackage

@@ hdl/b64sc_front.sv @@
// ----------------------------------------------------------------------------
// b64sc_front
// accepts input words, tracks the group state and builds result jobs
// ----------------------------------------------------------------------------
`include "base64_stream_codec_unit_assert.svh"

module b64sc_front (
	input  logic               clk,
	input  logic               arst_n,
	input  b64sc_pkg::cfg_ctl_t ctl,
	input  logic               item_valid,
	output logic               item_ready,
	input  b64sc_pkg::in_t     item,
	output logic               q_valid,
	input  logic               q_ready,
	output b64sc_pkg::job_t    q_data
);

	logic [17:0] gb_q, gb_n;
	logic [1:0]  gc_q, gc_n;
	logic [1:0]  pc_q, pc_n;
	logic        sp_q, sp_n;
	logic        err_q, err_n;

	b64sc_pkg::job_t    job;
	b64sc_pkg::sextet_t sx;
	logic [23:0] triple;
	logic [1:0]  n;
	logic [2:0]  k;
	logic [1:0]  nout;
	logic        ws, ok, bad, accept;

	assign item_ready = q_ready;
	assign accept     = item_valid && item_ready;
	assign q_valid    = accept && (job.count != 3'd0);
	assign q_data     = job;

	always_comb begin
		gb_n   = gb_q;
		gc_n   = gc_q;
		pc_n   = pc_q;
		sp_n   = sp_q;
		err_n  = err_q;
		job    = '0;
		triple = '0;
		k      = '0;
		nout   = '0;
		ok     = 1'b1;
		bad    = 1'b0;
		n      = 2'(gc_q + 2'd1);
		sx     = b64sc_pkg::dec_char(item.in_byte);
		ws     = (item.in_byte == b64sc_pkg::CH_SPACE) || (item.in_byte == b64sc_pkg::CH_TAB)
			|| (item.in_byte == b64sc_pkg::CH_CR) || (item.in_byte == b64sc_pkg::CH_LF);
		if (ctl.direction == b64sc_pkg::DIR_ENCODE) begin
			if (gc_q != 2'd2 && !item.in_last) begin
				gb_n = {2'b00, gb_q[7:0], item.in_byte};
				gc_n = n;
			end else begin
				unique case (gc_q)
					2'd0:    triple = {item.in_byte, 16'h0000};
					2'd1:    triple = {gb_q[7:0], item.in_byte, 8'h00};
					default: triple = {gb_q[15:0], item.in_byte};
				endcase
				for (int i = 0; i < b64sc_pkg::JOB_SLOTS; i++) begin
					job.res[i].out_byte  = (2'(i) <= n) ?
						b64sc_pkg::enc_char(triple[23-6*i -: 6]) : b64sc_pkg::PAD_CHAR;
					job.res[i].out_valid = 1'b1;
					job.res[i].out_last  = item.in_last && (i == 3);
				end
				job.count = 3'd4;
				gb_n  = '0;
				gc_n  = '0;
				pc_n  = '0;
				sp_n  = 1'b0;
				err_n = 1'b0;
			end
		end else begin
			if (!err_q && !ws) begin
				if (sx.is_bad) ok = 1'b0;
				else if (sx.is_pad) begin
					if (gc_q < 2'd2) ok = 1'b0;
					else begin
						sp_n = 1'b1;
						pc_n = 2'(pc_q + 2'd1);
					end
				end else if (sp_q) ok = 1'b0;
				if (!ok) err_n = 1'b1;
				else if (gc_q == 2'd3) begin
					triple = {gb_q, sx.is_pad ? 6'd0 : sx.value};
					nout   = (pc_n == 2'd3) ? 2'd1 : 2'(2'd3 - pc_n);
					for (int i = 0; i < 3; i++) begin
						if (2'(i) < nout) begin
							job.res[i].out_byte  = triple[23-8*i -: 8];
							job.res[i].out_valid = 1'b1;
						end
					end
					k    = {1'b0, nout};
					gb_n = '0;
					gc_n = '0;
					pc_n = '0;
				end else begin
					gb_n = {gb_q[11:0], sx.is_pad ? 6'd0 : sx.value};
					gc_n = n;
				end
			end
			if (item.in_last) begin
				bad = err_n || (gc_n != 2'd0);
				if (k != 3'd0 && !bad) begin
					job.res[2'(k - 3'd1)].out_last = 1'b1;
				end else begin
					job.res[k[1:0]].out_last  = 1'b1;
					job.res[k[1:0]].bad_input = bad;
					k = 3'(k + 3'd1);
				end
				gb_n  = '0;
				gc_n  = '0;
				pc_n  = '0;
				sp_n  = 1'b0;
				err_n = 1'b0;
			end
			job.count = k;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gb_q  <= '0;
			gc_q  <= '0;
			pc_q  <= '0;
			sp_q  <= 1'b0;
			err_q <= 1'b0;
		end else if (ctl.clear) begin
			gb_q  <= '0;
			gc_q  <= '0;
			pc_q  <= '0;
			sp_q  <= 1'b0;
			err_q <= 1'b0;
		end else if (accept) begin
			gb_q  <= gb_n;
			gc_q  <= gc_n;
			pc_q  <= pc_n;
			sp_q  <= sp_n;
			err_q <= err_n;
		end
	end

	// encode never flags malformed input
	`B64SC_ASSERT_IMP(a_enc_no_err, clk, arst_n, ctl.direction == b64sc_pkg::DIR_ENCODE, !err_q,
		"error flag set in encode")
	// a final word always leaves the group state empty
	`B64SC_ASSERT_NXT(a_last_clears, clk, arst_n, accept && item.in_last && !ctl.clear,
		(gc_q == 2'd0) && !sp_q && !err_q, "group state not cleared after last word")

endmodule

@@ hdl/b64sc_fifo.sv @@
// ----------------------------------------------------------------------------
// b64sc_fifo
// short job queue between the front and back parts
// ----------------------------------------------------------------------------
`include "base64_stream_codec_unit_assert.svh"

module b64sc_fifo #(
	parameter int DEPTH = b64sc_pkg::QUEUE_DEPTH
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            wr_valid,
	output logic            wr_ready,
	input  b64sc_pkg::job_t wr_data,
	output logic            rd_valid,
	input  logic            rd_ready,
	output b64sc_pkg::job_t rd_data
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	b64sc_pkg::job_t mem_q [DEPTH];
	logic [PTR_W-1:0] wp_q, rp_q;
	logic [CNT_W-1:0] count_q;
	logic push, pop;

	assign wr_ready = (count_q != CNT_W'(DEPTH));
	assign rd_valid = (count_q != '0);
	assign rd_data  = mem_q[rp_q];
	assign push     = wr_valid && wr_ready;
	assign pop      = rd_valid && rd_ready;

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q    <= '0;
			rp_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) wp_q <= (wp_q == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(wp_q + 1'b1);
			if (pop)  rp_q <= (rp_q == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(rp_q + 1'b1);
			unique case ({push, pop})
				2'b10:   count_q <= CNT_W'(count_q + 1'b1);
				2'b01:   count_q <= CNT_W'(count_q - 1'b1);
				default: count_q <= count_q;
			endcase
		end
	end

	// the front only pushes when there is room
	`B64SC_ASSERT_IMP(a_no_overflow, clk, arst_n, wr_valid, count_q < CNT_W'(DEPTH),
		"job pushed into full queue")

endmodule

@@ hdl/b64sc_back.sv @@
// ----------------------------------------------------------------------------
// b64sc_back
// plays out the result words of each job, one per cycle while result_ready is high
// ----------------------------------------------------------------------------
`include "base64_stream_codec_unit_assert.svh"

module b64sc_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            rd_valid,
	output logic            rd_ready,
	input  b64sc_pkg::job_t rd_data,
	output logic            result_valid,
	input  logic            result_ready,
	output b64sc_pkg::out_t result
);

	b64sc_pkg::job_t cur_q;
	logic       cur_valid_q;
	logic [1:0] idx_q;
	logic       last_slot, take, sent;

	assign result_valid = cur_valid_q;
	assign result       = cur_q.res[idx_q];
	assign sent         = cur_valid_q && result_ready;
	assign last_slot    = (idx_q == 2'(cur_q.count - 3'd1));
	assign take         = !cur_valid_q || (sent && last_slot);
	assign rd_ready     = take;

	always_ff @(posedge clk) begin
		if (take && rd_valid) cur_q <= rd_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_valid_q <= 1'b0;
			idx_q       <= '0;
		end else if (take) begin
			cur_valid_q <= rd_valid;
			idx_q       <= '0;
		end else if (sent) begin
			idx_q <= 2'(idx_q + 2'd1);
		end
	end

	// slot index stays inside the job
	`B64SC_ASSERT_IMP(a_idx_in_job, clk, arst_n, cur_valid_q, {1'b0, idx_q} < cur_q.count,
		"slot index beyond job length")
	// a stalled word holds its slot
	`B64SC_ASSERT_NXT(a_stall_holds, clk, arst_n, result_valid && !result_ready,
		result_valid && $stable(idx_q), "slot moved while stalled")

endmodule

@@ hdl/base64_stream_codec_unit.sv @@
// ----------------------------------------------------------------------------
// base64_stream_codec_unit
// streaming base64 encoder / decoder with an apb direction register
// ----------------------------------------------------------------------------
// The unit takes one input word per cycle (item) while the job queue has room and hands out
// result words one per cycle (result) while result_ready is high. A front part accepts each
// word, updates the group state and turns it into a job of zero to four result words; a back
// part plays the jobs out of the queue. Encode gives four result words per three input bytes;
// decode takes one character per word and gives about three result words per four characters,
// plus one status word on the final input when it yields no clean data byte. Results pass
// through the queue and the back job register. The direction register (byte address 0, bit 0:
// 0 encode, 1 decode) is to be written only while the unit is idle; the unit does not enforce
// this. Each write also discards any partial stream. In decode, bad_input on the final result
// word means the whole stream must be thrown away.

module base64_stream_codec_unit #(
	parameter int QUEUE_DEPTH = b64sc_pkg::QUEUE_DEPTH
) (
	input  logic                       clk,
	input  logic                       arst_n,
	// apb register port
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [b64sc_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]                pwdata,
	output logic [31:0]                prdata,
	output logic                       pready,
	// input words
	input  logic                       item_valid,
	output logic                       item_ready,
	input  b64sc_pkg::in_t             item,
	// result words
	output logic                       result_valid,
	input  logic                       result_ready,
	output b64sc_pkg::out_t            result
);

	logic dir_q;
	logic reg_hit, cfg_wr;
	b64sc_pkg::cfg_ctl_t ctl;

	// queue link between front and back
	logic            q_wr_valid, q_wr_ready;
	b64sc_pkg::job_t q_wr_data;
	logic            q_rd_valid, q_rd_ready;
	b64sc_pkg::job_t q_rd_data;

	// register decode: paddr[2] picks the register, low bits are byte lanes
	assign pready  = 1'b1;
	assign reg_hit = (paddr[2] == b64sc_pkg::REG_DIRECTION);
	assign cfg_wr  = psel && penable && pwrite && pready && reg_hit;
	assign prdata  = reg_hit ? {31'd0, dir_q} : 32'd0;

	// a direction write also wipes the stream state in the front
	assign ctl.direction = dir_q;
	assign ctl.clear     = cfg_wr;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dir_q <= b64sc_pkg::DIR_ENCODE;
		end else if (cfg_wr) begin
			dir_q <= pwdata[0];
		end
	end

	b64sc_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (ctl),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.item       (item),
		.q_valid    (q_wr_valid),
		.q_ready    (q_wr_ready),
		.q_data     (q_wr_data)
	);

	// short queue so either side can stall on its own
	b64sc_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (q_wr_valid),
		.wr_ready (q_wr_ready),
		.wr_data  (q_wr_data),
		.rd_valid (q_rd_valid),
		.rd_ready (q_rd_ready),
		.rd_data  (q_rd_data)
	);

	b64sc_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.rd_valid     (q_rd_valid),
		.rd_ready     (q_rd_ready),
		.rd_data      (q_rd_data),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

endmodule
